FILE: design/sira_pkg.sv
package sira_pkg;

   localparam int VALUE_W       = 32;
   localparam int SYMBOL_W      = 8;
   localparam int ALPHA_WORDS   = 4;
   localparam int ALPHA_WORD_W  = 64;
   localparam int ALPHA_SYMBOLS = ALPHA_WORDS * ALPHA_WORD_W / SYMBOL_W;
   localparam int MAX_SYMBOLS   = 32;
   localparam int COUNT_W       = 6;
   localparam int DIGIT_W       = $clog2(ALPHA_SYMBOLS);
   localparam int MAX_DIGITS    = VALUE_W;
   localparam int DIGIT_IDX_W   = $clog2(MAX_DIGITS);
   localparam int CHUNK_BITS    = 8;
   localparam int STEPS_PER_DIGIT = VALUE_W / CHUNK_BITS;
   localparam int STEP_W        = $clog2(STEPS_PER_DIGIT);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = ALPHA_WORD_W;
   localparam int REQ_DATA_W    = 32;
   localparam int RSP_DATA_W    = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_SYMBOL_COUNT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHABET_WORD0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHABET_WORD1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHABET_WORD2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHABET_WORD3 = 3'd4;

   localparam logic [SYMBOL_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [SYMBOL_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [SYMBOL_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [SYMBOL_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;

   typedef logic [ALPHA_SYMBOLS-1:0][SYMBOL_W-1:0] symbols_type;

   typedef struct packed {
      logic [COUNT_W-1:0] symbol_count;
      symbols_type        symbols;
   } cfg_type;

   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } work_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_SIGN,
      BACK_DIGITS
   } back_state_type;

endpackage

FILE: design/sira_front.sv
module sira_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [sira_pkg::VALUE_W-1:0] req_value,
   input  sira_pkg::cfg_type    cfg,
   output logic                 push_valid,
   input  logic                 push_ready,
   output sira_pkg::work_type   push_data
);

   logic                         hold_valid_ff, hold_valid_in;
   logic [sira_pkg::VALUE_W-1:0] hold_value_ff;
   logic                         alpha_ok_ff, alpha_ok_in;
   logic                         release_item;
   logic                         accept;

   // alphabet check, registered; the user keeps config stable while idle, the block does not enforce it
   always_comb begin
      alpha_ok_in = 1'b1;
      if (cfg.symbol_count < sira_pkg::COUNT_W'(2) ||
          cfg.symbol_count > sira_pkg::COUNT_W'(sira_pkg::MAX_SYMBOLS)) begin
         alpha_ok_in = 1'b0;
      end
      for (int i = 0; i < sira_pkg::ALPHA_SYMBOLS; i++) begin
         if (sira_pkg::COUNT_W'(i) < cfg.symbol_count) begin
            if (cfg.symbols[i] == sira_pkg::CHAR_NUL ||
                (cfg.symbols[i] >= sira_pkg::CHAR_TAB && cfg.symbols[i] <= sira_pkg::CHAR_CR) ||
                cfg.symbols[i] == sira_pkg::CHAR_SPACE ||
                cfg.symbols[i] == sira_pkg::CHAR_PLUS ||
                cfg.symbols[i] == sira_pkg::CHAR_MINUS) begin
               alpha_ok_in = 1'b0;
            end
            for (int j = i + 1; j < sira_pkg::ALPHA_SYMBOLS; j++) begin
               if (sira_pkg::COUNT_W'(j) < cfg.symbol_count &&
                   cfg.symbols[j] == cfg.symbols[i]) begin
                  alpha_ok_in = 1'b0;
               end
            end
         end
      end
   end

   // invalid alphabet drops the request
   assign release_item = hold_valid_ff && (!alpha_ok_ff || push_ready);
   assign req_tready   = !hold_valid_ff || release_item;
   assign accept       = req_tvalid && req_tready;
   assign push_valid   = hold_valid_ff && alpha_ok_ff;

   assign push_data.neg = hold_value_ff[sira_pkg::VALUE_W-1];
   assign push_data.mag = hold_value_ff[sira_pkg::VALUE_W-1] ?
                          (~hold_value_ff + sira_pkg::VALUE_W'(1)) : hold_value_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (release_item) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         alpha_ok_ff   <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         alpha_ok_ff   <= alpha_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_value_ff <= req_value;
      end
   end

endmodule

FILE: design/sira_queue.sv
module sira_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  sira_pkg::work_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output sira_pkg::work_type pop_data
);

   sira_pkg::work_type                 slots_ff [sira_pkg::QUEUE_DEPTH];
   logic [sira_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sira_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sira_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign push_ready = count_ff != sira_pkg::QUEUE_CNT_W'(sira_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sira_pkg::QUEUE_PTR_W'(sira_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + sira_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sira_pkg::QUEUE_PTR_W'(sira_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + sira_pkg::QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + sira_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - sira_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/sira_back.sv
module sira_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  sira_pkg::work_type    pop_data,
   input  sira_pkg::cfg_type     cfg,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [sira_pkg::SYMBOL_W-1:0] rsp_symbol,
   output logic                  rsp_last
);

   sira_pkg::back_state_type         state_ff, state_in;
   logic [sira_pkg::VALUE_W-1:0]     quot_ff, quot_in;
   logic [sira_pkg::DIGIT_W-1:0]     rem_ff, rem_in;
   logic [sira_pkg::STEP_W-1:0]      step_ff, step_in;
   logic                             neg_ff, neg_in;
   logic [sira_pkg::DIGIT_IDX_W-1:0] nd_ff, nd_in;
   logic [sira_pkg::DIGIT_IDX_W-1:0] rd_ff, rd_in;
   logic [sira_pkg::DIGIT_W-1:0]     stack_ff [sira_pkg::MAX_DIGITS];
   logic                             stack_we;
   logic                             out_valid_ff, out_valid_in;
   logic [sira_pkg::SYMBOL_W-1:0]    out_symbol_ff, out_symbol_in;
   logic                             out_last_ff, out_last_in;
   logic                             slot_free;

   logic [sira_pkg::DIGIT_W-1:0]     chunk_rem;
   logic [sira_pkg::VALUE_W-1:0]     chunk_quot;
   logic [sira_pkg::DIGIT_W:0]       trial;
   logic                             digit_done;
   logic                             number_done;

   // restoring division, eight quotient bits per cycle
   always_comb begin
      chunk_rem  = rem_ff;
      chunk_quot = quot_ff;
      trial      = '0;
      for (int k = 0; k < sira_pkg::CHUNK_BITS; k++) begin
         trial = {chunk_rem, chunk_quot[sira_pkg::VALUE_W-1]};
         if (trial >= cfg.symbol_count) begin
            chunk_rem  = sira_pkg::DIGIT_W'(trial - cfg.symbol_count);
            chunk_quot = {chunk_quot[sira_pkg::VALUE_W-2:0], 1'b1};
         end else begin
            chunk_rem  = trial[sira_pkg::DIGIT_W-1:0];
            chunk_quot = {chunk_quot[sira_pkg::VALUE_W-2:0], 1'b0};
         end
      end
   end

   assign digit_done  = (state_ff == sira_pkg::BACK_DIVIDE) &&
                        (step_ff == sira_pkg::STEP_W'(sira_pkg::STEPS_PER_DIGIT - 1));
   assign number_done = digit_done && ((chunk_quot == '0) ||
                        (nd_ff == sira_pkg::DIGIT_IDX_W'(sira_pkg::MAX_DIGITS - 1)));
   assign slot_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sira_pkg::BACK_IDLE: begin
            if (pop_valid) begin
               state_in = sira_pkg::BACK_DIVIDE;
            end
         end
         sira_pkg::BACK_DIVIDE: begin
            if (number_done) begin
               state_in = neg_ff ? sira_pkg::BACK_SIGN : sira_pkg::BACK_DIGITS;
            end
         end
         sira_pkg::BACK_SIGN: begin
            if (slot_free) begin
               state_in = sira_pkg::BACK_DIGITS;
            end
         end
         sira_pkg::BACK_DIGITS: begin
            if (slot_free && rd_ff == '0) begin
               state_in = sira_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = sira_pkg::BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop_ready     = 1'b0;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      neg_in        = neg_ff;
      nd_in         = nd_ff;
      rd_in         = rd_ff;
      stack_we      = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_symbol_in = out_symbol_ff;
      out_last_in   = out_last_ff;
      case (state_ff)
         sira_pkg::BACK_IDLE: begin
            pop_ready = 1'b1;
            quot_in   = pop_data.mag;
            neg_in    = pop_data.neg;
            rem_in    = '0;
            step_in   = '0;
            nd_in     = '0;
         end
         sira_pkg::BACK_DIVIDE: begin
            quot_in = chunk_quot;
            rem_in  = chunk_rem;
            step_in = step_ff + sira_pkg::STEP_W'(1);
            if (digit_done) begin
               stack_we = 1'b1;
               rem_in   = '0;
               nd_in    = nd_ff + sira_pkg::DIGIT_IDX_W'(1);
               rd_in    = nd_ff;
            end
         end
         sira_pkg::BACK_SIGN: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_symbol_in = sira_pkg::CHAR_MINUS;
               out_last_in   = 1'b0;
            end
         end
         sira_pkg::BACK_DIGITS: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_symbol_in = cfg.symbols[stack_ff[rd_ff]];
               out_last_in   = rd_ff == '0;
               rd_in         = rd_ff - sira_pkg::DIGIT_IDX_W'(1);
            end
         end
         default: begin
            out_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sira_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      neg_ff        <= neg_in;
      nd_ff         <= nd_in;
      rd_ff         <= rd_in;
      out_symbol_ff <= out_symbol_in;
      out_last_ff   <= out_last_in;
      if (stack_we) begin
         stack_ff[nd_ff] <= chunk_rem;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_symbol = out_symbol_ff;
   assign rsp_last   = out_last_ff;

endmodule

FILE: design/signed_int_to_radix_ascii.sv
// Signed 32-bit integer to ASCII text in a programmable radix.
// Request channel (req_): one signed value per request in req_tdata.
// Response channel (rsp_): one character per transfer in rsp_tdata, a minus
// sign first for negative values, then the digits most significant first;
// rsp_tlast marks the final character of a number.
// Control port (csr_): index 0 sets the radix (number of symbols in use),
// indexes 1 to 4 hold the digit symbols, eight bytes each, lowest byte first.
// Write it only while no number is in flight. A bad alphabet (fewer than two
// or more than 32 symbols, whitespace, plus, minus, zero byte or a repeated
// symbol) makes the block drop every request without a response.
// Timing: a request is registered in the input stage, then waits in a
// two-entry queue. The divider loop finds each digit at 8 quotient bits per
// cycle over 32 bits, and all digits of a number before its first character
// leaves; then one character leaves per cycle while the receiver is ready.
// The input side keeps taking requests while the queue has room.
// Reset clears all control registers to zero (empty alphabet, so invalid).
// A stalled receiver holds the current character; the divider then waits.
module signed_int_to_radix_ascii (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sira_pkg::REQ_DATA_W-1:0]     req_tdata,  // [31:0] value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sira_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [7:0] symbol
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [sira_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sira_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [sira_pkg::COUNT_W-1:0]                             symbol_count_ff;
   logic [sira_pkg::ALPHA_WORDS-1:0][sira_pkg::ALPHA_WORD_W-1:0] alphabet_ff;
   sira_pkg::cfg_type  cfg;
   logic               push_valid;
   logic               push_ready;
   sira_pkg::work_type push_data;
   logic               pop_valid;
   logic               pop_ready;
   sira_pkg::work_type pop_data;
   logic [sira_pkg::SYMBOL_W-1:0] rsp_symbol;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= '0;
         alphabet_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            sira_pkg::REG_SYMBOL_COUNT: begin
               symbol_count_ff <= csr_wdata[sira_pkg::COUNT_W-1:0];
            end
            sira_pkg::REG_ALPHABET_WORD0: begin
               alphabet_ff[0] <= csr_wdata;
            end
            sira_pkg::REG_ALPHABET_WORD1: begin
               alphabet_ff[1] <= csr_wdata;
            end
            sira_pkg::REG_ALPHABET_WORD2: begin
               alphabet_ff[2] <= csr_wdata;
            end
            sira_pkg::REG_ALPHABET_WORD3: begin
               alphabet_ff[3] <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.symbol_count = symbol_count_ff;
   assign cfg.symbols      = alphabet_ff;

   sira_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_value  (req_tdata[sira_pkg::VALUE_W-1:0]),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   sira_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   sira_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = rsp_symbol;

endmodule
